// ===== rtl/lpd_pkg.sv =====
package lpd_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int PIXEL_BITS = 8;

    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int SIZE_BITS = 11;
    localparam int POS_BITS  = 10;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [SIZE_BITS-1:0] COLS_RESET = SIZE_BITS'(1024);
    localparam logic [SIZE_BITS-1:0] ROWS_RESET = SIZE_BITS'(1024);
    localparam logic [SIZE_BITS-1:0] COLS_LIMIT = SIZE_BITS'(MAX_COLS);
    localparam logic [SIZE_BITS-1:0] ROWS_LIMIT = SIZE_BITS'(MAX_ROWS);

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [COL_BITS-1:0]   col_t;
    typedef logic [ROW_BITS-1:0]   row_t;
    typedef logic [SIZE_BITS-1:0]  size_t;
    typedef logic [POS_BITS-1:0]   pos_t;

    typedef enum logic
    {
        REG_FRAME_COLS = 1'b0,
        REG_FRAME_ROWS = 1'b1
    } reg_idx_t;

    // Effective frame size, already clamped to 1..MAX
    typedef struct packed
    {
        size_t cols;
        size_t rows;
    } frame_cfg_t;

    // Position of the current word and what it means for the centre above it
    typedef struct packed
    {
        row_t row;
        col_t col;
        logic judge;
        logic frame_end;
    } pos_info_t;

    // One line buffer entry: row r-2 (upper) and row r-1 (middle)
    typedef struct packed
    {
        pixel_t upper;
        pixel_t middle;
    } line_pair_t;

endpackage

// ===== rtl/lpd_if.sv =====
interface lpd_pix_if import lpd_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t pixel;
    logic   frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface lpd_peak_if import lpd_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   peak_found;
    pixel_t peak_value;
    pos_t   peak_row;
    pos_t   peak_col;
    logic   frame_end;

    modport source (output valid, output peak_found, output peak_value, output peak_row,
                     output peak_col, output frame_end, input ready);
    modport sink   (input valid, input peak_found, input peak_value, input peak_row,
                    input peak_col, input frame_end, output ready);
endinterface

// ===== rtl/local_peak_detector.sv =====
// Four-neighbour local maximum detector for a raster pixel stream.
//
// pixels: one pixel word per handshake (valid/ready), frame_start on the first
// pixel of a frame. peaks: one result word per pixel word, in the same order.
// A result judges the centre one row above the incoming pixel; peak_found is
// set when that centre is strictly above its four neighbours. Unjudged results
// (first two rows, edge columns) carry zeros in every field but
// frame_end, which marks the last pixel of the frame.
// Frame size comes from two APB registers: frame_cols at 0x0, frame_rows at 0x4.
//
// An accepted pixel passes the input stage, then the result register; throughput
// is one pixel per cycle while peaks is not stalled, set by the single write port
// of the combined line buffer (both previous rows share one entry, read at
// columns c and c+1).
// When peaks is stalled the output register holds; one more pixel is taken
// into the input stage, after which pixels.ready drops.
// Reset empties the pipeline, clears the position counters and sets both size
// registers to 1024. Line buffer contents are not cleared.
module local_peak_detector import lpd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    lpd_pix_if.sink                  pixels,
    lpd_peak_if.source               peaks
);

    frame_cfg_t cfg;
    pos_info_t  pos;
    logic       accept;
    logic       s1_adv;
    line_pair_t cur;
    line_pair_t ahead;
    line_pair_t wr_data;
    logic       found;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    pixel_t     s1_pix_reg;
    col_t       s1_col_reg;
    row_t       s1_row_reg;
    logic       s1_judge_reg;
    logic       s1_fend_reg;
    pixel_t     left_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_found_reg;
    pixel_t     out_value_reg;
    pos_t       out_row_reg;
    pos_t       out_col_reg;
    logic       out_fend_reg;

    lpd_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lpd_pos u_pos
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .frame_start (pixels.frame_start),
        .cfg         (cfg),
        .pos         (pos)
    );

    lpd_line_buf u_line_buf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr0 (pos.col),
        .rd_addr1 (pos.col + col_t'(1)),
        .wr_en    (s1_valid_reg),
        .wr_addr  (s1_col_reg),
        .wr_data  (wr_data),
        .rd_data0 (cur),
        .rd_data1 (ahead)
    );

    assign s1_adv       = s1_valid_reg && (!out_valid_reg || peaks.ready);
    assign pixels.ready = !s1_valid_reg || s1_adv;
    assign accept       = pixels.valid && pixels.ready;

    // Shift the column down a row: middle becomes upper, new pixel becomes middle
    assign wr_data.upper  = cur.middle;
    assign wr_data.middle = s1_pix_reg;

    // Left neighbour is the previous word's centre whenever a judgement is made
    assign found = (cur.middle > cur.upper) && (cur.middle > s1_pix_reg)
                   && (cur.middle > left_reg) && (cur.middle > ahead.middle);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (peaks.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pixels.pixel;
            s1_col_reg   <= pos.col;
            s1_row_reg   <= pos.row - row_t'(1);
            s1_judge_reg <= pos.judge;
            s1_fend_reg  <= pos.frame_end;
        end
        if (s1_adv)
        begin
            left_reg      <= cur.middle;
            out_found_reg <= s1_judge_reg && found;
            out_value_reg <= s1_judge_reg ? cur.middle : '0;
            out_row_reg   <= s1_judge_reg ? POS_BITS'(s1_row_reg) : '0;
            out_col_reg   <= s1_judge_reg ? POS_BITS'(s1_col_reg) : '0;
            out_fend_reg  <= s1_fend_reg;
        end
    end

    assign peaks.valid      = out_valid_reg;
    assign peaks.peak_found = out_found_reg;
    assign peaks.peak_value = out_value_reg;
    assign peaks.peak_row   = out_row_reg;
    assign peaks.peak_col   = out_col_reg;
    assign peaks.frame_end  = out_fend_reg;

endmodule

// ===== rtl/lpd_regs.sv =====
module lpd_regs import lpd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output frame_cfg_t               cfg
);

    size_t    cols_reg;
    size_t    rows_reg;
    reg_idx_t sel;
    logic     wr;

    assign pready = 1'b1;
    assign sel    = reg_idx_t'(paddr[2]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end
        else if (wr)
        begin
            case (sel)
                REG_FRAME_COLS: cols_reg <= pwdata[SIZE_BITS-1:0];
                REG_FRAME_ROWS: rows_reg <= pwdata[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_FRAME_COLS: prdata = APB_DATA_BITS'(cols_reg);
            REG_FRAME_ROWS: prdata = APB_DATA_BITS'(rows_reg);
            default:        prdata = '0;
        endcase
    end

    // Zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (cols_reg == '0)
            cfg.cols = SIZE_BITS'(1);
        else if (cols_reg > COLS_LIMIT)
            cfg.cols = COLS_LIMIT;
        else
            cfg.cols = cols_reg;

        if (rows_reg == '0)
            cfg.rows = SIZE_BITS'(1);
        else if (rows_reg > ROWS_LIMIT)
            cfg.rows = ROWS_LIMIT;
        else
            cfg.rows = rows_reg;
    end

endmodule

// ===== rtl/lpd_pos.sv =====
module lpd_pos import lpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       frame_start,
    input  frame_cfg_t cfg,
    output pos_info_t  pos
);

    row_t  row_reg;
    row_t  row_next;
    col_t  col_reg;
    col_t  col_next;
    row_t  r;
    col_t  c;
    size_t c_inc;
    size_t r_inc;
    logic  row_end;

    assign r       = frame_start ? '0 : row_reg;
    assign c       = frame_start ? '0 : col_reg;
    assign c_inc   = SIZE_BITS'(c) + SIZE_BITS'(1);
    assign r_inc   = SIZE_BITS'(r) + SIZE_BITS'(1);
    assign row_end = c_inc >= cfg.cols;

    // Centre (r-1, c) is interior when r-1 is neither the first nor the last row
    assign pos.row       = r;
    assign pos.col       = c;
    assign pos.judge     = (r >= row_t'(2)) && (SIZE_BITS'(r) < cfg.rows)
                           && (c != '0) && (c_inc < cfg.cols);
    assign pos.frame_end = row_end && (r_inc >= cfg.rows);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = pos.frame_end ? '0 : r_inc[ROW_BITS-1:0];
            end
            else
            begin
                col_next = c_inc[COL_BITS-1:0];
                row_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// ===== rtl/lpd_line_buf.sv =====
module lpd_line_buf import lpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rd_en,
    input  col_t       rd_addr0,
    input  col_t       rd_addr1,
    input  logic       wr_en,
    input  col_t       wr_addr,
    input  line_pair_t wr_data,
    output line_pair_t rd_data0,
    output line_pair_t rd_data1
);

    line_pair_t mem [MAX_COLS];
    line_pair_t q0_reg;
    line_pair_t q1_reg;
    line_pair_t byp_data_reg;
    logic       byp0_reg;
    logic       byp1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            q0_reg       <= mem[rd_addr0];
            q1_reg       <= mem[rd_addr1];
            byp_data_reg <= wr_data;
        end
    end

    // A write landing on the same edge as a read is forwarded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp0_reg <= 1'b0;
            byp1_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp0_reg <= wr_en && (wr_addr == rd_addr0);
            byp1_reg <= wr_en && (wr_addr == rd_addr1);
        end
    end

    assign rd_data0 = byp0_reg ? byp_data_reg : q0_reg;
    assign rd_data1 = byp1_reg ? byp_data_reg : q1_reg;

endmodule
